>>> hdl/gdil_pkg.sv
// gdil_pkg: shared sizes, register codes, result type and helpers for the
// grid obstacle dilation block. Depends on nothing.
`default_nettype none

package gdil_pkg;

  // grid geometry and largest growth radius
  localparam int GRID_W     = 256;
  localparam int GRID_H     = 256;
  localparam int MAX_RADIUS = 8;

  // counter and index widths
  localparam int COL_W  = $clog2(GRID_W);
  localparam int ROW_W  = $clog2(GRID_H);
  localparam int QROW_W = $clog2(GRID_H + MAX_RADIUS);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int NCELL  = 2 * MAX_RADIUS + 1;
  localparam int IDX_W  = $clog2(NCELL);
  localparam int VEC_W  = 2 * MAX_RADIUS;
  localparam int SUM_W  = $clog2(GRID_W + 2 * MAX_RADIUS) + 1;

  // stream and register port
  localparam int TDATA_W    = 8;
  localparam int CFG_W      = 4;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr above the byte offset
  localparam logic REG_GROW_RADIUS = 1'b0;
  localparam logic [CFG_W-1:0] GROW_RADIUS_RESET = CFG_W'(1);

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int PEND_W     = FIFO_CNT_W + 1;

  typedef struct packed {
    logic grown;
    logic frame_end;
  } out_item_t;

  // radius register clamped to the largest supported radius
  function automatic logic [RAD_W-1:0] sat_radius(input logic [CFG_W-1:0] r);
    logic [RAD_W-1:0] res;
    if (32'(r) > MAX_RADIUS) begin
      res = RAD_W'(MAX_RADIUS);
    end else begin
      res = RAD_W'(r);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/gdil_cell.sv
// gdil_cell: one tap of the horizontal window chain; holds one pixel and
// flags it when it lies in the current window row. Uses gdil_pkg.
`default_nettype none

module gdil_cell (
  input  wire logic                         clk,
  input  wire logic                         shift,
  input  wire logic [gdil_pkg::IDX_W-1:0]   idx,
  input  wire logic [gdil_pkg::RAD_W-1:0]   radius,
  input  wire logic [gdil_pkg::COL_W-1:0]   qcol,
  input  wire logic                         din,
  output logic                              dout,
  output logic                              hit
);

  logic                       pix;
  logic [gdil_pkg::SUM_W-1:0] kx;
  logic [gdil_pkg::SUM_W-1:0] rx;
  logic [gdil_pkg::SUM_W-1:0] cx;
  logic [gdil_pkg::SUM_W-1:0] wm1;
  logic                       incl;

  always_ff @(posedge clk) begin
    if (shift) begin
      pix <= din;
    end
  end

  // tap k sits at column qcol + radius - k; keep it when that column is on the
  // same row and within radius of the center
  always_comb begin
    kx   = gdil_pkg::SUM_W'(idx);
    rx   = gdil_pkg::SUM_W'(radius);
    cx   = gdil_pkg::SUM_W'(qcol);
    wm1  = gdil_pkg::SUM_W'(gdil_pkg::GRID_W - 1);
    incl = (kx <= rx + rx) && (kx <= rx + cx) && (kx + (wm1 - cx) >= rx);
  end

  assign dout = pix;
  assign hit  = pix & incl;

endmodule

`default_nettype wire

>>> hdl/gdil_ram.sv
// gdil_ram: generic single-write, single-read memory with registered read.
// No dependencies.
`default_nettype none

module gdil_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/gdil_ofifo.sv
// gdil_ofifo: small result queue between the dilation pipeline and the
// output stream. Uses gdil_pkg.
`default_nettype none

module gdil_ofifo (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire gdil_pkg::out_item_t             push_item,
  input  wire logic                            pop,
  output gdil_pkg::out_item_t                  head,
  output logic                                 not_empty,
  output logic [gdil_pkg::FIFO_CNT_W-1:0]      count
);

  gdil_pkg::out_item_t                 slots [gdil_pkg::FIFO_DEPTH];
  logic [gdil_pkg::FIFO_PTR_W-1:0]     wr_ptr;
  logic [gdil_pkg::FIFO_PTR_W-1:0]     rd_ptr;
  logic [gdil_pkg::FIFO_CNT_W-1:0]     count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + gdil_pkg::FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - gdil_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + gdil_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gdil_pkg::FIFO_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

endmodule

`default_nettype wire

>>> hdl/grid_obstacle_dilation_top.sv
// grid_obstacle_dilation_top: streaming square-window dilation of a raster
// occupancy grid. Uses gdil_pkg, gdil_cell, gdil_ram and gdil_ofifo.
`default_nettype none

// The block takes one transaction per clock while s_tready is high and grows
// every obstacle by a square window of R cells each way, R being grow_radius
// (clamped to MAX_RADIUS) latched at the first pixel of a frame. A pixel
// transaction (tuser = 0) carries one grid cell in raster order; the result
// for cell p passes stage 1 and stage 2 after the transaction carrying cell
// p + R*GRID_W + R and is then queued, so the first R*GRID_W + R pixels give
// no result. Once the whole grid is in, every transaction (flush or pixel,
// whose value is then dropped) pushes out one more result until the last one,
// marked with tlast; a flush before the grid is complete is taken and dropped.
// The sustained rate of one transaction per clock is set by the shift of the
// horizontal window chain and one read plus one write per clock on the column
// history memory; a four-entry result queue absorbs output stalls. The window
// is separable: a chain of 2*MAX_RADIUS+1 cells forms the row OR, and a memory
// of GRID_W words, each holding the row ORs of the last 2*MAX_RADIUS rows for
// that column, forms the column OR. Row and column limits are applied by
// position, so no memory clearing is needed after reset or between frames.

module grid_obstacle_dilation_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [gdil_pkg::TDATA_W-1:0]        s_tdata,  // [0] occupied
  input  wire logic                                s_tuser,  // [0] mode
  // output stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [gdil_pkg::TDATA_W-1:0]        m_tdata,  // [0] grown
  output logic                                     m_tlast,  // frame_end
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [gdil_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [gdil_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [gdil_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  // register
  logic [gdil_pkg::CFG_W-1:0]   grow_radius;
  logic                         reg_wr;

  // input side position and frame control
  logic [gdil_pkg::COL_W-1:0]   in_col;
  logic [gdil_pkg::COL_W-1:0]   in_col_next;
  logic [gdil_pkg::ROW_W-1:0]   in_row;
  logic [gdil_pkg::ROW_W-1:0]   in_row_next;
  logic                         in_done;
  logic                         in_done_next;
  logic                         frame_open;
  logic [gdil_pkg::RAD_W-1:0]   frame_radius;
  logic [gdil_pkg::RAD_W-1:0]   rad_now;
  logic [gdil_pkg::RAD_W-1:0]   lead;
  logic [gdil_pkg::RAD_W-1:0]   lead_next;

  // window center position (R pixels behind the newest one)
  logic [gdil_pkg::COL_W-1:0]   q_col;
  logic [gdil_pkg::COL_W-1:0]   q_col_next;
  logic [gdil_pkg::QROW_W-1:0]  q_row;
  logic [gdil_pkg::QROW_W-1:0]  q_row_next;

  logic                         s_xfer;
  logic                         step;
  logic                         pix_in;
  logic                         h_now;
  logic                         out_now;
  logic                         end_now;

  // stage 1: row OR from the chain
  logic                         s1_valid;
  logic                         s1_out;
  logic                         s1_end;
  logic [gdil_pkg::COL_W-1:0]   s1_col;
  logic [gdil_pkg::QROW_W-1:0]  s1_row;
  logic [gdil_pkg::RAD_W-1:0]   s1_radius;

  // stage 2: column OR from the history memory
  logic                         s2_valid;
  logic                         s2_out;
  logic                         s2_end;
  logic                         s2_h;
  logic [gdil_pkg::COL_W-1:0]   s2_col;
  logic [gdil_pkg::QROW_W-1:0]  s2_row;
  logic [gdil_pkg::RAD_W-1:0]   s2_radius;

  logic [gdil_pkg::NCELL:0]     chain;
  logic [gdil_pkg::NCELL-1:0]   hits;
  logic                         h_row;

  logic [gdil_pkg::VEC_W-1:0]   hist_rd;
  logic [gdil_pkg::VEC_W-1:0]   hist_wr;
  logic                         vert;

  gdil_pkg::out_item_t          push_item;
  gdil_pkg::out_item_t          head;
  logic                         push;
  logic                         pop;
  logic [gdil_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [gdil_pkg::PEND_W-1:0]  pending;

  // ---------------------------------------------------------------- registers

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grow_radius <= gdil_pkg::GROW_RADIUS_RESET;
    end else if (reg_wr) begin
      unique case (paddr[gdil_pkg::APB_ADDR_W-1])
        gdil_pkg::REG_GROW_RADIUS: grow_radius <= pwdata[gdil_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (psel && !pwrite) begin
      unique case (paddr[gdil_pkg::APB_ADDR_W-1])
        gdil_pkg::REG_GROW_RADIUS: prdata = gdil_pkg::APB_DATA_W'(grow_radius);
        default: prdata = '0;
      endcase
    end
  end

  // --------------------------------------------------------- step control

  // room for every result still in flight plus the one this transaction
  // might add once it has passed stage 1 and stage 2
  assign pending = gdil_pkg::PEND_W'(fifo_count)
                 + gdil_pkg::PEND_W'(s1_valid & s1_out)
                 + gdil_pkg::PEND_W'(s2_valid & s2_out);
  assign s_tready = (pending < gdil_pkg::PEND_W'(gdil_pkg::FIFO_DEPTH));
  assign s_xfer   = s_tvalid && s_tready;

  // flush before the grid is complete does nothing; afterwards every
  // transaction moves one zero pixel past the bottom of the grid
  assign step   = s_xfer && (in_done || !s_tuser);
  assign pix_in = !in_done && s_tdata[0];

  assign rad_now = frame_open ? frame_radius : gdil_pkg::sat_radius(grow_radius);
  assign h_now   = (lead == rad_now);
  assign out_now = (q_row >= gdil_pkg::QROW_W'(rad_now));
  assign end_now = h_now
                && (q_row == gdil_pkg::QROW_W'(gdil_pkg::GRID_H - 1)
                           + gdil_pkg::QROW_W'(rad_now))
                && (q_col == gdil_pkg::COL_W'(gdil_pkg::GRID_W - 1));

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    in_done_next = in_done;
    lead_next    = lead;
    q_col_next   = q_col;
    q_row_next   = q_row;
    if (step) begin
      // input raster position
      if (!in_done) begin
        if (in_col == gdil_pkg::COL_W'(gdil_pkg::GRID_W - 1)) begin
          in_col_next = '0;
          if (in_row == gdil_pkg::ROW_W'(gdil_pkg::GRID_H - 1)) begin
            in_row_next  = '0;
            in_done_next = 1'b1;
          end else begin
            in_row_next = in_row + gdil_pkg::ROW_W'(1);
          end
        end else begin
          in_col_next = in_col + gdil_pkg::COL_W'(1);
        end
      end
      // the first R pixels only fill the chain
      if (!h_now) begin
        lead_next = lead + gdil_pkg::RAD_W'(1);
      end else if (q_col == gdil_pkg::COL_W'(gdil_pkg::GRID_W - 1)) begin
        q_col_next = '0;
        q_row_next = q_row + gdil_pkg::QROW_W'(1);
      end else begin
        q_col_next = q_col + gdil_pkg::COL_W'(1);
      end
      // last result of the frame: back to the start
      if (end_now) begin
        in_col_next  = '0;
        in_row_next  = '0;
        in_done_next = 1'b0;
        lead_next    = '0;
        q_col_next   = '0;
        q_row_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col       <= '0;
      in_row       <= '0;
      in_done      <= 1'b0;
      lead         <= '0;
      q_col        <= '0;
      q_row        <= '0;
      frame_open   <= 1'b0;
      frame_radius <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
    end else begin
      in_col   <= in_col_next;
      in_row   <= in_row_next;
      in_done  <= in_done_next;
      lead     <= lead_next;
      q_col    <= q_col_next;
      q_row    <= q_row_next;
      s1_valid <= step && h_now;
      s2_valid <= s1_valid;
      if (step) begin
        frame_open <= !end_now;
        if (!frame_open) begin
          frame_radius <= rad_now;
        end
      end
    end
  end

  // stage payload, carried with the item so a new frame cannot disturb it
  always_ff @(posedge clk) begin
    s1_out    <= out_now;
    s1_end    <= end_now;
    s1_col    <= q_col;
    s1_row    <= q_row;
    s1_radius <= rad_now;
    s2_out    <= s1_out;
    s2_end    <= s1_end;
    s2_col    <= s1_col;
    s2_row    <= s1_row;
    s2_radius <= s1_radius;
    s2_h      <= h_row;
  end

  // -------------------------------------------------- horizontal window chain

  // cell k holds the pixel k places behind the newest; the center is cell R
  assign chain[0] = pix_in;

  for (genvar k = 0; k < gdil_pkg::NCELL; k++) begin : g_cell
    gdil_cell u_cell (
      .clk    (clk),
      .shift  (step),
      .idx    (gdil_pkg::IDX_W'(k)),
      .radius (s1_radius),
      .qcol   (s1_col),
      .din    (chain[k]),
      .dout   (chain[k+1]),
      .hit    (hits[k])
    );
  end

  assign h_row = |hits;

  // ------------------------------------------------------ column history

  // word for each column: bit j-1 holds the row OR of center row minus j
  gdil_ram #(
    .WIDTH (gdil_pkg::VEC_W),
    .DEPTH (gdil_pkg::GRID_W)
  ) u_hist (
    .clk   (clk),
    .we    (s2_valid),
    .waddr (s2_col),
    .wdata (hist_wr),
    .raddr (s1_col),
    .rdata (hist_rd)
  );

  // rows above the top of the grid are left out by position
  always_comb begin
    vert = s2_h;
    for (int j = 1; j <= gdil_pkg::VEC_W; j++) begin
      if ((j <= 2 * int'(s2_radius)) && (j <= int'(s2_row))) begin
        vert = vert | hist_rd[j-1];
      end
    end
    hist_wr = {hist_rd[gdil_pkg::VEC_W-2:0], s2_h};
  end

  // --------------------------------------------------------- result queue

  assign push                = s2_valid && s2_out;
  assign push_item.grown     = vert;
  assign push_item.frame_end = s2_end;
  assign pop                 = m_tvalid && m_tready;

  gdil_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (m_tvalid),
    .count     (fifo_count)
  );

  assign m_tdata = gdil_pkg::TDATA_W'(head.grown);
  assign m_tlast = head.frame_end;

endmodule

`default_nettype wire

>>> dv/grid_obstacle_dilation_top_tb.sv
// grid_obstacle_dilation_top_tb: self-checking bench for the streaming square-window
// dilation block, with its own frame image, window search and register copy.
// Depends on gdil_pkg and grid_obstacle_dilation_top.
`timescale 1ns / 100ps

module grid_obstacle_dilation_top_tb;

  localparam int CLK_HALF = 10;
  localparam int CLK_PERIOD = 2 * CLK_HALF;
  localparam int FRAME_PIX = gdil_pkg::GRID_W * gdil_pkg::GRID_H;
  // cycles allowed for the block to settle once nothing is expected
  localparam int SETTLE_CYCLES = 16;
  // time limit for the whole run, several times over the worst case
  localparam longint LIMIT_NS = 64'd200_000 * CLK_PERIOD;
  localparam logic [gdil_pkg::APB_ADDR_W-1:0] GROW_RADIUS_ADDR =
    {gdil_pkg::REG_GROW_RADIUS, 2'b00};
  // random transactions after the opening table, and where the sender pauses
  localparam int N_RANDOM = 634;
  localparam int HOLD_AT = 300;

  // tuser codes on the input stream
  typedef enum logic {MODE_PIXEL = 1'b0, MODE_FLUSH = 1'b1} item_mode_t;
  // how a directed row is checked
  typedef enum logic {CHK_MODEL, CHK_NONE} probe_chk_t;
  // obstacle density of one stretch of pixels
  typedef enum int {DENS_EMPTY, DENS_SPARSE, DENS_MID, DENS_HALF, DENS_FULL} density_t;

  typedef struct packed {
    item_mode_t mode;
    logic       occ;
    probe_chk_t chk;
  } probe_row_t;

  // opening rows at the reset radius; no result before a full row and one
  // pixel have gone in
  localparam int N_PROBES = 16;
  localparam probe_row_t PROBES [0:N_PROBES-1] = '{
    '{MODE_FLUSH, 1'b0, CHK_NONE},   // flush with no frame open
    '{MODE_FLUSH, 1'b1, CHK_NONE},
    '{MODE_PIXEL, 1'b1, CHK_NONE},   // first pixel opens the frame
    '{MODE_PIXEL, 1'b1, CHK_NONE},
    '{MODE_FLUSH, 1'b1, CHK_NONE},   // flush mid-frame is dropped
    '{MODE_PIXEL, 1'b0, CHK_MODEL},
    '{MODE_PIXEL, 1'b0, CHK_MODEL},
    '{MODE_PIXEL, 1'b1, CHK_MODEL},
    '{MODE_FLUSH, 1'b0, CHK_MODEL},
    '{MODE_PIXEL, 1'b0, CHK_MODEL},
    '{MODE_PIXEL, 1'b1, CHK_MODEL},
    '{MODE_PIXEL, 1'b1, CHK_MODEL},
    '{MODE_PIXEL, 1'b0, CHK_MODEL},
    '{MODE_FLUSH, 1'b1, CHK_MODEL},
    '{MODE_PIXEL, 1'b0, CHK_MODEL},
    '{MODE_PIXEL, 1'b1, CHK_MODEL}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input stream
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [gdil_pkg::TDATA_W-1:0]    s_tdata = '0;   // [0] occupied
  logic                            s_tuser = 1'b0; // [0] mode
  // output stream
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [gdil_pkg::TDATA_W-1:0]    m_tdata;        // [0] grown
  logic                            m_tlast;        // frame_end
  // register port
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [gdil_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [gdil_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [gdil_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  int mismatch_count = 0;

  // results still to come out of the block, oldest first
  gdil_pkg::out_item_t expected_cells[$];

  // shadow of the block: register, latched radius, frame image and positions
  logic [gdil_pkg::CFG_W-1:0] radius_reg = gdil_pkg::GROW_RADIUS_RESET;
  logic [gdil_pkg::RAD_W-1:0] frame_rad = '0;
  logic [gdil_pkg::ROW_W:0]   feed_row = '0;
  logic [gdil_pkg::COL_W-1:0] feed_col = '0;
  logic [gdil_pkg::ROW_W:0]   emit_row = '0;
  logic [gdil_pkg::COL_W-1:0] emit_col = '0;
  bit                         grid_filled = 1'b0;
  bit                         frame_busy = 1'b0;
  bit                         grid_img [FRAME_PIX];

  grid_obstacle_dilation_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // idle cycles before the next transaction on either side
  function automatic int pace_gap();
    return int'($urandom_range(0, 7));
  endfunction

  // any obstacle inside the clamped square around (row, col)
  function automatic bit window_hit(input int row, input int col, input int rad);
    int rlo, rhi, clo, chi;
    rlo = (row >= rad) ? row - rad : 0;
    rhi = (row + rad < gdil_pkg::GRID_H) ? row + rad : gdil_pkg::GRID_H - 1;
    clo = (col >= rad) ? col - rad : 0;
    chi = (col + rad < gdil_pkg::GRID_W) ? col + rad : gdil_pkg::GRID_W - 1;
    for (int y = rlo; y <= rhi; y++) begin
      for (int x = clo; x <= chi; x++) begin
        if (grid_img[y * gdil_pkg::GRID_W + x]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // advance the shadow by one accepted transaction, report the result it causes
  task automatic dilate_step(input item_mode_t mode, input logic occ,
                             output bit got, output gdil_pkg::out_item_t res);
    int arrived, pend, need;
    got = 1'b0;
    res = '0;
    if (!grid_filled) begin
      // flush before the grid is complete does nothing
      if (mode == MODE_FLUSH) return;
      // radius latched at the first pixel, clamped to the largest supported
      if (!frame_busy) begin
        frame_rad = (int'(radius_reg) > gdil_pkg::MAX_RADIUS) ?
                    gdil_pkg::RAD_W'(gdil_pkg::MAX_RADIUS) :
                    gdil_pkg::RAD_W'(radius_reg);
        frame_busy = 1'b1;
      end
      grid_img[int'(feed_row) * gdil_pkg::GRID_W + int'(feed_col)] = occ;
      if (int'(feed_col) == gdil_pkg::GRID_W - 1) begin
        feed_col = '0;
        if (int'(feed_row) == gdil_pkg::GRID_H - 1) begin
          feed_row = '0;
          grid_filled = 1'b1;
        end else begin
          feed_row++;
        end
      end else begin
        feed_col++;
      end
    end
    // while draining, pixels act as flush ticks
    arrived = grid_filled ? FRAME_PIX : int'(feed_row) * gdil_pkg::GRID_W + int'(feed_col);
    pend = int'(emit_row) * gdil_pkg::GRID_W + int'(emit_col);
    need = pend + int'(frame_rad) * gdil_pkg::GRID_W + int'(frame_rad);
    if (need > FRAME_PIX - 1) need = FRAME_PIX - 1;
    if (arrived <= need) return;
    res.grown = window_hit(int'(emit_row), int'(emit_col), int'(frame_rad));
    res.frame_end = (pend == FRAME_PIX - 1);
    got = 1'b1;
    if (res.frame_end) begin
      // all positions back to zero, next pixel opens a new frame
      feed_row = '0;
      feed_col = '0;
      emit_row = '0;
      emit_col = '0;
      grid_filled = 1'b0;
      frame_busy = 1'b0;
    end else if (int'(emit_col) == gdil_pkg::GRID_W - 1) begin
      emit_col = '0;
      emit_row++;
    end else begin
      emit_col++;
    end
  endtask

  // one transaction on the input stream, then the shadow steps
  task automatic send_item(input item_mode_t mode, input logic occ,
                           output bit got, output gdil_pkg::out_item_t res);
    int gap;
    gap = pace_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= gdil_pkg::TDATA_W'(occ);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    dilate_step(mode, occ, got, res);
  endtask

  task automatic feed_item(input item_mode_t mode, input logic occ);
    bit got;
    gdil_pkg::out_item_t res;
    send_item(mode, occ, got, res);
    if (got) expected_cells.push_back(res);
  endtask

  // stop sending, let every expected result come out, then let the block settle
  task automatic drain_expectations();
    s_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_radius_reg();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= GROW_RADIUS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== gdil_pkg::APB_DATA_W'(radius_reg)) begin
      mismatch_count++;
      $display("%0t grow_radius read: expected %0h actual %0h", $time, radius_reg, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // register write, then read it back
  task automatic write_radius(input logic [gdil_pkg::CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= GROW_RADIUS_ADDR;
    pwdata <= gdil_pkg::APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    radius_reg = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    check_radius_reg();
  endtask

  // random pixels with a stray flush now and then; after hold_at + 1 transactions
  // the sender waits for all results and the radius is rewritten mid-frame
  task automatic stream_random(input int n_items, input int hold_at);
    density_t seg_kind;
    logic occ;
    seg_kind = DENS_SPARSE;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 31) == 0) begin
        // stray flush while the grid is still coming in
        feed_item(MODE_FLUSH, 1'($urandom_range(0, 1)));
      end else begin
        // new density every 32 columns
        if (feed_col[4:0] == 5'd0) begin
          case ($urandom_range(0, 15))
            0, 1:                   seg_kind = DENS_EMPTY;
            2, 3, 4, 5, 6, 7, 8, 9: seg_kind = DENS_SPARSE;
            10, 11, 12:             seg_kind = DENS_MID;
            13, 14:                 seg_kind = DENS_HALF;
            default:                seg_kind = DENS_FULL;
          endcase
        end
        case (seg_kind)
          DENS_EMPTY:  occ = 1'b0;
          DENS_SPARSE: occ = ($urandom_range(0, 63) == 0);
          DENS_MID:    occ = ($urandom_range(0, 7) == 0);
          DENS_HALF:   occ = 1'($urandom_range(0, 1));
          default:     occ = 1'b1;
        endcase
        feed_item(MODE_PIXEL, occ);
      end
      if (i == hold_at) begin
        // all-ones radius mid-frame: the open frame keeps the radius it latched
        drain_expectations();
        write_radius(gdil_pkg::CFG_W'(15));
      end
    end
  endtask

  // result side: random stalls, every transaction checked against the oldest expectation
  initial begin : result_sink
    int stall;
    gdil_pkg::out_item_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pace_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (expected_cells.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: expected none actual grown %b frame_end %b",
                 $time, m_tdata[0], m_tlast);
      end else begin
        want = expected_cells.pop_front();
        if (m_tdata !== gdil_pkg::TDATA_W'(want.grown)) begin
          mismatch_count++;
          $display("%0t grown: expected %b actual %h", $time, want.grown, m_tdata);
        end
        if (m_tlast !== want.frame_end) begin
          mismatch_count++;
          $display("%0t frame_end: expected %b actual %b", $time, want.frame_end, m_tlast);
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("grid_obstacle_dilation_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    bit got;
    gdil_pkg::out_item_t res;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register after reset
    check_radius_reg();

    // frame at the reset radius: opening rows from the table
    for (int i = 0; i < N_PROBES; i++) begin
      send_item(PROBES[i].mode, PROBES[i].occ, got, res);
      case (PROBES[i].chk)
        CHK_MODEL: begin
          if (got) expected_cells.push_back(res);
        end
        default: ;
      endcase
    end

    // random content with one pause until everything has come out
    stream_random(N_RANDOM, HOLD_AT);
    drain_expectations();

    if (mismatch_count == 0) begin
      $display("grid_obstacle_dilation_top: match");
    end else begin
      $display("grid_obstacle_dilation_top: mismatch");
    end
    $finish;
  end

endmodule
